FILE: sv/bfsrw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsrw_pkg
// Shared types, codes and helpers for the bit field stream reader/writer.
// ----------------------------------------------------------------------------
package bfsrw_pkg;

   localparam int BUFFER_BYTES   = 1024;
   localparam int MAX_FIELD_BITS = 64;
   localparam int ADDR_W         = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   localparam int CAP_BITS       = BUFFER_BYTES * 8;

   localparam int FIELD_W  = 64;
   localparam int COUNT_W  = 7;
   localparam int CURSOR_W = 14;
   localparam int SPAN_BYTES = 9;

   localparam logic [CURSOR_W-1:0] SIZE_RESET = 14'd8192;

   typedef enum logic [2:0] {
      MODE_READ    = 3'd0,
      MODE_WRITE   = 3'd1,
      MODE_SEEK    = 3'd2,
      MODE_ADVANCE = 3'd3,
      MODE_REWIND  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_EOS  = 2'd1,
      ST_FAIL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_READ,
      ENG_WFETCH,
      ENG_WRITE,
      ENG_RESP
   } eng_state_type;

   typedef struct packed {
      logic [FIELD_W-1:0]  read_data;
      logic [COUNT_W-1:0]  bits_done;
      logic [1:0]          status;
      logic [CURSOR_W-1:0] position;
   } res_type;

   // low n bits set, all bits for n of a full word or more
   function automatic logic [FIELD_W-1:0] field_mask(input logic [COUNT_W-1:0] n);
      logic [FIELD_W-1:0] m;
      if (n >= COUNT_W'(FIELD_W)) begin
         m = '1;
      end else begin
         m = (FIELD_W'(1) << n) - FIELD_W'(1);
      end
      return m;
   endfunction

endpackage

FILE: sv/bfsrw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsrw channel interfaces
// Valid/ready channels for requests, responses and the size register write.
// ----------------------------------------------------------------------------
interface bfsrw_req_if;
   logic                           valid;
   logic                           ready;
   logic [2:0]                     mode;
   logic [bfsrw_pkg::COUNT_W-1:0]  count_bits;
   logic [bfsrw_pkg::FIELD_W-1:0]  write_data;
   logic [bfsrw_pkg::CURSOR_W-1:0] amount;
   modport source (output valid, mode, count_bits, write_data, amount, input ready);
   modport sink   (input valid, mode, count_bits, write_data, amount, output ready);
endinterface

interface bfsrw_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bfsrw_pkg::FIELD_W-1:0]  read_data;
   logic [bfsrw_pkg::COUNT_W-1:0]  bits_done;
   logic [1:0]                     status;
   logic [bfsrw_pkg::CURSOR_W-1:0] position;
   modport source (output valid, read_data, bits_done, status, position, input ready);
   modport sink   (input valid, read_data, bits_done, status, position, output ready);
endinterface

interface bfsrw_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bfsrw_pkg::CURSOR_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: sv/bit_field_stream_reader_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_field_stream_reader_writer_core
// Bit cursor over a byte store: read, write, seek, advance and rewind.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command word (mode, count_bits, write_data, amount);
//   rsp_chan returns one word per command (read_data, bits_done, status,
//   position). csr_chan writes the stream size in bits; it is always ready
//   and should be written only while no command is in flight.
// Sequence from accept to response valid:
//   seek, advance, rewind, failed or zero-length access: no store access
//   read of B bytes (B = bytes the field touches, 1..9): one store read per byte
//   write of B bytes: one store write per byte, after a fetch of the first
//   byte when the field starts inside one (that byte is fetched and merged first)
// One command is in flight at a time; the core is ready for the next word in
// the cycle after the response moves into the output register. The byte walk
// over the byte-wide store, one shared address at a time, sets how long a
// command occupies the core.
// Reset clears the cursor to zero and the size to 8192 bits; the store
// contents are undefined until written. A stalled receiver holds the
// response in the output register; one more command may finish behind it.
// ----------------------------------------------------------------------------
module bit_field_stream_reader_writer_core (
   input  logic        clock,
   input  logic        reset,
   bfsrw_req_if.sink   req_chan,
   bfsrw_rsp_if.source rsp_chan,
   bfsrw_csr_if.sink   csr_chan
);

   logic [bfsrw_pkg::CURSOR_W-1:0] size_ff, size_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   bfsrw_pkg::res_type             rsp_data_ff, rsp_data_in;

   logic                           eng_valid;
   logic                           eng_ready;
   bfsrw_pkg::res_type             eng_res;

   assign csr_chan.ready = 1'b1;
   assign size_in = csr_chan.valid ? csr_chan.data : size_ff;

   bfsrw_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .size_reg  (size_ff),
      .res_valid (eng_valid),
      .res_ready (eng_ready),
      .res       (eng_res)
   );

   // load the output register whenever it is empty or being drained
   assign eng_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_valid && eng_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff.read_data;
   assign rsp_chan.bits_done = rsp_data_ff.bits_done;
   assign rsp_chan.status    = rsp_data_ff.status;
   assign rsp_chan.position  = rsp_data_ff.position;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= bfsrw_pkg::SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   a_fail_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == bfsrw_pkg::ST_FAIL |->
         rsp_chan.bits_done == '0 && rsp_chan.read_data == '0)
      else $error("failed command returned data or a bit count");

   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.bits_done <= 7'(bfsrw_pkg::MAX_FIELD_BITS))
      else $error("bit count above field limit");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("second command accepted while one is in flight");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      eng_valid && !eng_ready |-> rsp_valid_ff && !rsp_chan.ready)
      else $error("engine response held without a stalled output");
`endif

endmodule

FILE: sv/bfsrw_byte_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsrw_byte_ram
// Byte-wide store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfsrw_byte_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [bfsrw_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                   wr_data,
   input  logic                         rd_en,
   input  logic [bfsrw_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                   rd_data
);

   logic [7:0] mem [bfsrw_pkg::BUFFER_BYTES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold the last read until the next one
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: sv/bfsrw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsrw_engine
// Cursor, clamping and the byte sequencer that walks the store per word.
// ----------------------------------------------------------------------------
module bfsrw_engine (
   input  logic                           clock,
   input  logic                           reset,
   bfsrw_req_if.sink                      req_chan,
   input  logic [bfsrw_pkg::CURSOR_W-1:0] size_reg,
   output logic                           res_valid,
   input  logic                           res_ready,
   output bfsrw_pkg::res_type             res
);

   localparam int AW = bfsrw_pkg::ADDR_W;
   localparam int CW = bfsrw_pkg::CURSOR_W;
   localparam int NW = bfsrw_pkg::COUNT_W;
   localparam int FW = bfsrw_pkg::FIELD_W;
   localparam int SB = bfsrw_pkg::SPAN_BYTES;

   bfsrw_pkg::eng_state_type state_ff, state_in;

   logic [CW-1:0]        cursor_ff, cursor_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [2:0]           sh_ff, sh_in;
   logic [AW-1:0]        base_ff, base_in;
   logic [3:0]           nbytes_ff, nbytes_in;
   logic [3:0]           idx_ff, idx_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [3:0]           rd_slot_ff, rd_slot_in;
   logic [SB-1:0][7:0]   acc_ff, acc_in;
   logic [SB-1:0][7:0]   wbits_ff, wbits_in;
   logic [1:0]           status_ff, status_in;
   logic                 is_read_ff, is_read_in;

   logic                 accept;
   logic                 issue;
   bfsrw_pkg::eng_state_type go_state;

   logic                 ram_wr_en, ram_rd_en;
   logic [AW-1:0]        ram_addr;
   logic [7:0]           ram_wr_data, ram_rd_data;

   logic [SB*8-1:0]      acc_shift;

   assign accept = (state_ff == bfsrw_pkg::ENG_IDLE) && req_chan.valid;
   assign issue  = (idx_ff < nbytes_ff);

   // datapath: evaluate the word at accept, then gather or scatter bytes
   always_comb begin
      logic [CW-1:0] size;
      logic [NW-1:0] clip;
      logic [CW-1:0] rem;
      logic [NW-1:0] n;
      logic [CW:0]   sum;
      logic [7:0]    span;
      logic [SB*8-1:0] wide;

      cursor_in  = cursor_ff;
      n_in       = n_ff;
      sh_in      = sh_ff;
      base_in    = base_ff;
      nbytes_in  = nbytes_ff;
      idx_in     = idx_ff;
      acc_in     = acc_ff;
      wbits_in   = wbits_ff;
      status_in  = status_ff;
      is_read_in = is_read_ff;
      go_state   = bfsrw_pkg::ENG_RESP;

      size = (32'(size_reg) < bfsrw_pkg::CAP_BITS) ? size_reg : CW'(bfsrw_pkg::CAP_BITS);
      clip = (32'(req_chan.count_bits) > bfsrw_pkg::MAX_FIELD_BITS) ?
             NW'(bfsrw_pkg::MAX_FIELD_BITS) : req_chan.count_bits;
      rem  = size - cursor_ff;
      n    = (CW'(clip) > rem) ? NW'(rem) : clip;
      sum  = {1'b0, cursor_ff} + {1'b0, req_chan.amount};
      span = 8'(cursor_ff[2:0]) + 8'(n) + 8'd7;
      wide = (SB*8)'(req_chan.write_data & bfsrw_pkg::field_mask(n)) << cursor_ff[2:0];

      if (accept) begin
         sh_in      = cursor_ff[2:0];
         base_in    = AW'(cursor_ff >> 3);
         wbits_in   = wide;
         idx_in     = '0;
         n_in       = '0;
         nbytes_in  = '0;
         status_in  = bfsrw_pkg::ST_FAIL;
         is_read_in = (req_chan.mode == bfsrw_pkg::MODE_READ);
         unique case (req_chan.mode)
            bfsrw_pkg::MODE_READ, bfsrw_pkg::MODE_WRITE: begin
               if (cursor_ff < size) begin
                  n_in      = n;
                  nbytes_in = (n == '0) ? 4'd0 : span[6:3];
                  cursor_in = cursor_ff + CW'(n);
                  status_in = (cursor_ff + CW'(n) == size) ? bfsrw_pkg::ST_EOS
                                                           : bfsrw_pkg::ST_OK;
                  if (n != '0) begin
                     if (req_chan.mode == bfsrw_pkg::MODE_READ) begin
                        go_state = bfsrw_pkg::ENG_READ;
                     end else if (cursor_ff[2:0] != 3'd0) begin
                        go_state = bfsrw_pkg::ENG_WFETCH;
                     end else begin
                        go_state = bfsrw_pkg::ENG_WRITE;
                     end
                  end
               end
            end
            bfsrw_pkg::MODE_SEEK: begin
               if (req_chan.amount < size) begin
                  cursor_in = req_chan.amount;
                  status_in = bfsrw_pkg::ST_OK;
               end
            end
            bfsrw_pkg::MODE_ADVANCE: begin
               if (sum < {1'b0, size}) begin
                  cursor_in = sum[CW-1:0];
                  status_in = bfsrw_pkg::ST_OK;
               end
            end
            bfsrw_pkg::MODE_REWIND: begin
               cursor_in = (req_chan.amount > cursor_ff) ? '0 : cursor_ff - req_chan.amount;
               status_in = bfsrw_pkg::ST_OK;
            end
            default: begin
            end
         endcase
      end

      if (rd_pend_ff) begin
         acc_in[rd_slot_ff] = ram_rd_data;
      end
      if ((state_ff == bfsrw_pkg::ENG_READ && issue) || state_ff == bfsrw_pkg::ENG_WRITE) begin
         idx_in = idx_ff + 4'd1;
      end
   end

   assign rd_pend_in = ram_rd_en && (state_ff == bfsrw_pkg::ENG_READ);
   assign rd_slot_in = idx_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfsrw_pkg::ENG_IDLE: begin
            if (accept) begin
               state_in = go_state;
            end
         end
         bfsrw_pkg::ENG_READ: begin
            if (!issue && !rd_pend_ff) begin
               state_in = bfsrw_pkg::ENG_RESP;
            end
         end
         bfsrw_pkg::ENG_WFETCH: begin
            state_in = bfsrw_pkg::ENG_WRITE;
         end
         bfsrw_pkg::ENG_WRITE: begin
            if (idx_ff == nbytes_ff - 4'd1) begin
               state_in = bfsrw_pkg::ENG_RESP;
            end
         end
         bfsrw_pkg::ENG_RESP: begin
            if (res_ready) begin
               state_in = bfsrw_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = bfsrw_pkg::ENG_IDLE;
         end
      endcase
   end

   assign acc_shift = acc_ff >> sh_ff;

   // outputs
   always_comb begin
      req_chan.ready = (state_ff == bfsrw_pkg::ENG_IDLE);
      ram_rd_en      = (state_ff == bfsrw_pkg::ENG_READ && issue) ||
                       (state_ff == bfsrw_pkg::ENG_WFETCH);
      ram_wr_en      = (state_ff == bfsrw_pkg::ENG_WRITE);
      ram_addr       = base_ff + AW'(idx_ff);
      // first byte of an unaligned field merges into what is already there
      if (idx_ff == 4'd0 && sh_ff != 3'd0) begin
         ram_wr_data = ram_rd_data | wbits_ff[idx_ff];
      end else begin
         ram_wr_data = wbits_ff[idx_ff];
      end
      res_valid     = (state_ff == bfsrw_pkg::ENG_RESP);
      res.read_data = is_read_ff ? (acc_shift[FW-1:0] & bfsrw_pkg::field_mask(n_ff)) : '0;
      res.bits_done = n_ff;
      res.status    = status_ff;
      res.position  = cursor_ff;
   end

   bfsrw_byte_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bfsrw_pkg::ENG_IDLE;
         cursor_ff  <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cursor_ff  <= cursor_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      sh_ff      <= sh_in;
      base_ff    <= base_in;
      nbytes_ff  <= nbytes_in;
      idx_ff     <= idx_in;
      rd_slot_ff <= rd_slot_in;
      acc_ff     <= acc_in;
      wbits_ff   <= wbits_in;
      status_ff  <= status_in;
      is_read_ff <= is_read_in;
   end

endmodule

FILE: bench/bit_field_stream_reader_writer_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_field_stream_reader_writer_core_checker
// Watches the command, response and size channels of the bit field stream
// core, keeps its own copy of the byte store, cursor and stream size, and
// compares every response word field by field against the predicted one.
// ----------------------------------------------------------------------------
module bit_field_stream_reader_writer_core_checker (
   input  logic  clock,
   input  logic  reset,
   bfsrw_req_if  req_chan,
   bfsrw_rsp_if  rsp_chan,
   bfsrw_csr_if  csr_chan,
   output int    fail_count,
   output int    pending,
   output int    checked
);
   import bfsrw_pkg::*;

   logic [7:0]          shadow_bytes [BUFFER_BYTES];
   int                  cursor_pos;
   logic [CURSOR_W-1:0] size_bits;
   res_type             pending_responses [$];
   int                  mismatches = 0;
   int                  compared = 0;

   // one command against the shadow store; moves the cursor as the core does
   function automatic res_type apply_command(input logic [2:0] op,
                                             input logic [COUNT_W-1:0] cnt_in,
                                             input logic [FIELD_W-1:0] wdata,
                                             input logic [CURSOR_W-1:0] amt);
      res_type r;
      int      size;
      int      n;
      int      idx;
      int      sh;
      r = '0;
      r.status = ST_FAIL;
      size = (int'(size_bits) < CAP_BITS) ? int'(size_bits) : CAP_BITS;
      case (op)
         MODE_READ, MODE_WRITE: begin
            if (cursor_pos < size) begin
               n = int'(cnt_in);
               if (n > MAX_FIELD_BITS) n = MAX_FIELD_BITS;
               if (n > size - cursor_pos) n = size - cursor_pos;
               for (int i = 0; i < n; i++) begin
                  idx = cursor_pos >> 3;
                  sh  = cursor_pos & 7;
                  if (op == MODE_READ) begin
                     r.read_data[i] = shadow_bytes[idx][sh];
                  end else if (sh == 0) begin
                     // a bit landing at bit 0 replaces the whole byte
                     shadow_bytes[idx] = {7'd0, wdata[i]};
                  end else begin
                     shadow_bytes[idx][sh] = shadow_bytes[idx][sh] | wdata[i];
                  end
                  cursor_pos++;
               end
               r.bits_done = COUNT_W'(n);
               r.status = (cursor_pos == size) ? ST_EOS : ST_OK;
            end
         end
         MODE_SEEK: begin
            if (int'(amt) < size) begin
               cursor_pos = int'(amt);
               r.status = ST_OK;
            end
         end
         MODE_ADVANCE: begin
            if (cursor_pos + int'(amt) < size) begin
               cursor_pos = cursor_pos + int'(amt);
               r.status = ST_OK;
            end
         end
         MODE_REWIND: begin
            cursor_pos = (int'(amt) > cursor_pos) ? 0 : cursor_pos - int'(amt);
            r.status = ST_OK;
         end
         default: begin
         end
      endcase
      r.position = CURSOR_W'(cursor_pos);
      return r;
   endfunction

   task automatic report_field(input string field, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         cursor_pos = 0;
         size_bits  = SIZE_RESET;
         pending_responses.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) size_bits = csr_chan.data;
         // retire before predicting: a word accepted now cannot answer at this edge
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_responses.size() == 0) begin
               mismatches++;
               $display("%0t: response word with none expected, expected none, actual %h",
                        $time, {rsp_chan.read_data, rsp_chan.bits_done, rsp_chan.status,
                                rsp_chan.position});
            end else begin
               want = pending_responses.pop_front();
               report_field("read_data", want.read_data, rsp_chan.read_data);
               report_field("bits_done", FIELD_W'(want.bits_done), FIELD_W'(rsp_chan.bits_done));
               report_field("status", FIELD_W'(want.status), FIELD_W'(rsp_chan.status));
               report_field("position", FIELD_W'(want.position), FIELD_W'(rsp_chan.position));
               compared++;
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            pending_responses.push_back(apply_command(req_chan.mode, req_chan.count_bits,
                                                      req_chan.write_data, req_chan.amount));
         end
      end
      fail_count <= mismatches;
      pending    <= pending_responses.size();
      checked    <= compared;
   end

endmodule

FILE: bench/bit_field_stream_reader_writer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_field_stream_reader_writer_core_tb
// Fills the whole byte store with aligned writes, runs a directed set of
// boundary commands, then random command phases over several stream sizes
// and idle profiles. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module bit_field_stream_reader_writer_core_tb;
   import bfsrw_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_PHASES  = 8;
   localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

   logic clock = 1'b0;
   logic reset;
   int   src_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   cycles = 0;
   int   words_sent = 0;
   int   size_settings = 0;
   int   cur_size = int'(SIZE_RESET);
   int   fail_count;
   int   pending;
   int   checked;

   // size per phase, -1 picks one at random; words per phase
   int phase_size  [NUM_PHASES] = '{8192, 1, 8191, 64, 0, 16383, 9, -1};
   int phase_words [NUM_PHASES] = '{170, 30, 170, 90, 20, 170, 50, 150};

   bfsrw_req_if req_chan ();
   bfsrw_rsp_if rsp_chan ();
   bfsrw_csr_if csr_chan ();

   bit_field_stream_reader_writer_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   bit_field_stream_reader_writer_core_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("bit_field_stream_reader_writer_core_tb: FAIL");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic set_idle_profile(input int profile);
      case (profile % 4)
         0: begin src_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin src_idle_pct = 82; rsp_stall_pct = 0;  end
         2: begin src_idle_pct = 0;  rsp_stall_pct = 82; end
         default: begin src_idle_pct = 32; rsp_stall_pct = 32; end
      endcase
   endtask

   task automatic send_word(input logic [2:0] op, input logic [COUNT_W-1:0] cnt,
                            input logic [FIELD_W-1:0] wd, input logic [CURSOR_W-1:0] amt);
      if ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < src_idle_pct) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= op;
      req_chan.count_bits <= cnt;
      req_chan.write_data <= wd;
      req_chan.amount     <= amt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
   endtask

   // drain every response before touching the size register
   task automatic set_stream_size(input int value);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= CURSOR_W'(value);
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      cur_size = value;
      size_settings++;
   endtask

   task automatic random_word();
      int          pick;
      int          eff;
      int          cnt;
      int          amt;
      logic [2:0]  op;
      logic [63:0] wd;
      eff  = (cur_size < CAP_BITS) ? cur_size : CAP_BITS;
      pick = $urandom_range(99);
      wd   = {$urandom, $urandom};
      cnt  = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(64);
      amt  = $urandom_range(16383);
      if (pick < 30) begin
         op = MODE_READ;
      end else if (pick < 60) begin
         op = MODE_WRITE;
      end else if (pick < 75) begin
         op = MODE_SEEK;
         // mostly in range, half of those close to the end of the stream
         if (eff > 0 && $urandom_range(7) != 0) begin
            if ($urandom_range(1) == 0) amt = $urandom_range(eff - 1);
            else amt = eff - 1 - $urandom_range((eff > 70) ? 70 : eff - 1);
         end
      end else if (pick < 85) begin
         op = MODE_ADVANCE;
         if ($urandom_range(3) != 0) amt = $urandom_range(200);
      end else if (pick < 95) begin
         op = MODE_REWIND;
         if ($urandom_range(3) != 0) amt = $urandom_range(200);
      end else begin
         op = 3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
      end
      send_word(op, COUNT_W'(cnt), wd, CURSOR_W'(amt));
   endtask

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_READ;
      req_chan.count_bits = '0;
      req_chan.write_data = '0;
      req_chan.amount     = '0;
      csr_chan.valid      = 1'b0;
      csr_chan.data       = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_stream_size(CAP_BITS);
      // fill the whole store with aligned words so no read sees an unwritten byte
      for (int i = 0; i < BUFFER_BYTES / 8; i++) begin
         send_word(MODE_WRITE, COUNT_W'(MAX_FIELD_BITS), {$urandom, $urandom}, '0);
      end

      set_idle_profile(3);
      send_word(MODE_READ, 7'd8, '0, '0);           // cursor at the end
      send_word(MODE_WRITE, 7'd8, '1, '0);
      send_word(MODE_SEEK, '0, '0, 14'd0);
      send_word(MODE_READ, 7'd0, '0, '0);           // zero count
      send_word(MODE_READ, 7'd127, '0, '0);         // count cut to 64
      send_word(MODE_READ, 7'd1, '0, '0);
      send_word(MODE_WRITE, 7'd7, 64'h55, '0);      // starts inside a byte
      send_word(MODE_SEEK, '0, '0, 14'd65);
      send_word(MODE_READ, 7'd7, '0, '0);
      send_word(MODE_SEEK, '0, '0, 14'd8);
      send_word(MODE_WRITE, 7'd1, 64'h1, '0);       // whole byte replaced
      send_word(MODE_SEEK, '0, '0, 14'd3);
      send_word(MODE_WRITE, 7'd64, '1, '0);
      send_word(MODE_SEEK, '0, '0, 14'd3);
      send_word(MODE_READ, 7'd64, '0, '0);
      send_word(MODE_SEEK, '0, '0, 14'd8191);
      send_word(MODE_READ, 7'd64, '0, '0);          // clamped, end of stream
      send_word(MODE_SEEK, '0, '0, 14'd8192);
      send_word(MODE_SEEK, '0, '0, 14'd16383);
      send_word(MODE_ADVANCE, '0, '0, 14'd16383);
      send_word(MODE_REWIND, '0, '0, 14'd16383);    // saturate at zero
      send_word(MODE_ADVANCE, '0, '0, 14'd0);
      send_word(MODE_ADVANCE, '0, '0, 14'd8191);
      send_word(MODE_ADVANCE, '0, '0, 14'd1);
      send_word(MODE_REWIND, '0, '0, 14'd0);
      for (logic [3:0] m = 4'(MODE_UNUSED_LO); m <= 4'(MODE_UNUSED_HI); m++) begin
         send_word(m[2:0], 7'd64, '1, 14'd5);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         set_stream_size((phase_size[p] < 0) ? $urandom_range(1, CAP_BITS) : phase_size[p]);
         set_idle_profile(p);
         for (int k = 0; k < phase_words[p]; k++) random_word();
      end

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (16) @(posedge clock);
      $display("covered %0d command words over %0d stream sizes and four idle profiles",
               words_sent, size_settings);
      $display("%0d response words compared, %0d mismatches", checked, fail_count);
      if (fail_count == 0) begin
         $display("bit_field_stream_reader_writer_core_tb: PASS");
      end else begin
         $display("bit_field_stream_reader_writer_core_tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/bfsrw_pkg.sv
sv/bfsrw_if.sv
sv/bfsrw_byte_ram.sv
sv/bfsrw_engine.sv
sv/bit_field_stream_reader_writer_core.sv
bench/bit_field_stream_reader_writer_core_checker.sv
bench/bit_field_stream_reader_writer_core_tb.sv
